// File: rtl/assert_macros.svh
// Assertion macros used by the checker module tcpa_chk.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/tcpa_pkg.sv
// Package of the threshold CPU packing allocator: sizes, codes and types.
// No dependencies; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package tcpa_pkg;

	localparam int NODES     = 8;
	localparam int CPUS      = 32;
	localparam int FRAC_BITS = 16;
	localparam int UTIL_BITS = FRAC_BITS + 4;
	localparam int NODE_W    = $clog2(NODES);
	localparam int CPU_W     = $clog2(CPUS);
	localparam int ADDR_W    = NODE_W + CPU_W;
	localparam int DEPTH     = NODES * CPUS;
	localparam int THR_W     = 17;
	localparam int TIME_W    = 32;
	localparam int DVD_W     = TIME_W + FRAC_BITS;

	localparam logic [THR_W-1:0] THR_RESET = 17'd58982;

	typedef logic [UTIL_BITS-1:0] util_t;
	localparam util_t UTIL_MAX = '1;

	typedef logic [2:0] status_t;
	localparam status_t ST_PLACED      = 3'd0;
	localparam status_t ST_NO_WORKLOAD = 3'd1;
	localparam status_t ST_NO_TARGET   = 3'd2;
	localparam status_t ST_ABSENT      = 3'd3;
	localparam status_t ST_NO_CPUS     = 3'd4;
	localparam status_t ST_NONE_FITS   = 3'd5;
	localparam status_t ST_CONFIG      = 3'd6;

	typedef logic [1:0] action_t;
	localparam action_t ACT_CLEAR = 2'd0;
	localparam action_t ACT_LOAD  = 2'd1;
	localparam action_t ACT_PLACE = 2'd2;

endpackage

// File: rtl/tcpa_div.sv
// Restoring divider: (runtime << FRAC_BITS) / period, one quotient bit a cycle.
// Depends on tcpa_pkg.
`timescale 1ns / 1ps

module tcpa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [tcpa_pkg::TIME_W-1:0]  runtime,
	input  logic [tcpa_pkg::TIME_W-1:0]  period,
	output logic                         done,
	output tcpa_pkg::util_t              quot
);

	localparam int CNT_W = $clog2(tcpa_pkg::DVD_W);

	logic                        run_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [tcpa_pkg::TIME_W-1:0] rem_q;
	logic [tcpa_pkg::TIME_W-1:0] div_q;
	logic [tcpa_pkg::DVD_W-1:0]  dq_q;
	logic                        zero_q;

	logic [tcpa_pkg::TIME_W:0]   rem_sh;
	logic [tcpa_pkg::TIME_W:0]   diff;
	logic                        ge;

	assign rem_sh = {rem_q, dq_q[tcpa_pkg::DVD_W-1]};
	assign diff   = rem_sh - {1'b0, div_q};
	assign ge     = !diff[tcpa_pkg::TIME_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CNT_W'(0)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dq_q   <= {runtime, {tcpa_pkg::FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			div_q  <= period;
			zero_q <= (period == '0);
			cnt_q  <= CNT_W'(tcpa_pkg::DVD_W - 1);
		end else if (run_q) begin
			// shift in one dividend bit, subtract when it goes
			rem_q <= ge ? diff[tcpa_pkg::TIME_W-1:0] : rem_sh[tcpa_pkg::TIME_W-1:0];
			dq_q  <= {dq_q[tcpa_pkg::DVD_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 :
		(|dq_q[tcpa_pkg::DVD_W-1:tcpa_pkg::UTIL_BITS]) ? tcpa_pkg::UTIL_MAX :
		dq_q[tcpa_pkg::UTIL_BITS-1:0];

endmodule

// File: rtl/threshold_cpu_packing_allocator_unit.sv
// Top level of the threshold CPU packing allocator.
// Depends on tcpa_pkg and tcpa_div.
//
// Channel   Handshake                 Payload
// item in   start / busy              action .. task_period
// result    res_valid (one cycle)     status, cpu_index, new_util
// config    cfg_valid / cfg_ready     cfg_data (util_threshold)
//
// After reset the utilization memory is swept to zero, one entry a cycle,
// with busy high. A clear item starts the same sweep.
// Clear, load, unused and rejected place items answer in the next cycle.
// A place item answers after the bit-serial divider, the affinity read and
// check, then, if that misses, a priming step and a scan of the CPUs from the
// highest down through the memory port. Results cannot be stalled; busy alone holds off items.
`timescale 1ns / 1ps

module threshold_cpu_packing_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [tcpa_pkg::NODE_W-1:0]   node_index,
	input  logic [tcpa_pkg::CPUS-1:0]     cpu_mask,
	input  logic                          has_workload,
	input  logic                          has_target,
	input  logic                          affinity_any,
	input  logic [tcpa_pkg::CPU_W-1:0]    affinity_cpu,
	input  logic [tcpa_pkg::TIME_W-1:0]   task_runtime,
	input  logic [tcpa_pkg::TIME_W-1:0]   task_period,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcpa_pkg::THR_W-1:0]    cfg_data,
	output logic                          res_valid,
	output logic [2:0]                    status,
	output logic [tcpa_pkg::CPU_W-1:0]    cpu_index,
	output logic [tcpa_pkg::UTIL_BITS-1:0] new_util
);

	typedef enum logic [5:0] {
		S_CLR    = 6'b000001,
		S_IDLE   = 6'b000010,
		S_DIV    = 6'b000100,
		S_AFF    = 6'b001000,
		S_AFFCHK = 6'b010000,
		S_SCAN   = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [tcpa_pkg::ADDR_W-1:0]     clr_cnt_q;
	logic [tcpa_pkg::THR_W-1:0]      thr_q;
	logic [tcpa_pkg::NODES-1:0]      present_q;
	logic [tcpa_pkg::CPUS-1:0]       mask_q [tcpa_pkg::NODES];

	// latched place item
	logic [tcpa_pkg::NODE_W-1:0]     node_q;
	logic [tcpa_pkg::CPUS-1:0]       mask_sel_q;
	logic                            aff_any_q;
	logic [tcpa_pkg::CPU_W-1:0]      aff_cpu_q;
	tcpa_pkg::util_t                 tu_q;

	// scan pipeline
	logic [tcpa_pkg::CPU_W-1:0]      scan_idx_q;
	logic [tcpa_pkg::CPU_W-1:0]      chk_cpu_q;
	logic                            chk_vld_q;

	// utilization memory
	tcpa_pkg::util_t                 util_mem [tcpa_pkg::DEPTH];
	tcpa_pkg::util_t                 rd_data_q;
	logic                            mem_we;
	logic [tcpa_pkg::ADDR_W-1:0]     mem_wa;
	logic [tcpa_pkg::ADDR_W-1:0]     mem_ra;
	tcpa_pkg::util_t                 mem_wd;

	// result register
	logic                            res_valid_q;
	tcpa_pkg::status_t               status_q;
	logic [tcpa_pkg::CPU_W-1:0]      cpu_q;
	tcpa_pkg::util_t                 util_q;

	logic                            accept;
	logic [tcpa_pkg::CPUS-1:0]       mask_rd;
	logic                            place_go;
	logic                            div_done;
	tcpa_pkg::util_t                 div_quot;
	logic [tcpa_pkg::UTIL_BITS:0]    sum;
	logic                            fits;
	tcpa_pkg::util_t                 nu;
	logic                            aff_ok;
	logic                            aff_hit;
	logic                            scan_hit;
	logic                            scan_end;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign mask_rd   = mask_q[node_index];

	// a place item that passes every early check goes to the divider
	assign place_go = accept && (action == tcpa_pkg::ACT_PLACE) && has_workload &&
		has_target && present_q[node_index] && (mask_rd != '0);

	tcpa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (place_go),
		.runtime (task_runtime),
		.period  (task_period),
		.done    (div_done),
		.quot    (div_quot)
	);

	// fit test and saturating update on the entry just read
	assign sum  = {1'b0, rd_data_q} + {1'b0, tu_q};
	assign fits = (sum <= (tcpa_pkg::UTIL_BITS+1)'(thr_q));
	assign nu   = sum[tcpa_pkg::UTIL_BITS] ? tcpa_pkg::UTIL_MAX : sum[tcpa_pkg::UTIL_BITS-1:0];

	assign aff_ok   = !aff_any_q && ({1'b0, aff_cpu_q} < (tcpa_pkg::CPU_W+1)'(tcpa_pkg::CPUS)) &&
		mask_sel_q[aff_cpu_q];
	assign aff_hit  = (state_q == S_AFFCHK) && aff_ok && fits;
	assign scan_hit = (state_q == S_SCAN) && chk_vld_q && mask_sel_q[chk_cpu_q] && fits;
	assign scan_end = (state_q == S_SCAN) && chk_vld_q && (chk_cpu_q == '0);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_cnt_q;
		mem_wd = '0;
		mem_ra = {node_q, scan_idx_q};
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_AFF: begin
				mem_ra = {node_q, aff_cpu_q};
			end
			S_AFFCHK: begin
				mem_we = aff_hit;
				mem_wa = {node_q, aff_cpu_q};
				mem_wd = nu;
			end
			S_SCAN: begin
				mem_we = scan_hit;
				mem_wa = {node_q, chk_cpu_q};
				mem_wd = nu;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			util_mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= util_mem[mem_ra];
	end

	// node masks: written by load items, read once at acceptance
	always_ff @(posedge clk) begin
		if (accept && action == tcpa_pkg::ACT_LOAD) begin
			mask_q[node_index] <= cpu_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			node_q     <= node_index;
			mask_sel_q <= mask_rd;
			aff_any_q  <= affinity_any;
			aff_cpu_q  <= affinity_cpu;
		end
		if (div_done) begin
			tu_q <= div_quot;
		end
		if (state_q == S_SCAN) begin
			scan_idx_q <= scan_idx_q - tcpa_pkg::CPU_W'(1);
			chk_cpu_q  <= scan_idx_q;
		end else begin
			scan_idx_q <= tcpa_pkg::CPU_W'(tcpa_pkg::CPUS - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			thr_q       <= tcpa_pkg::THR_RESET;
			present_q   <= '0;
			chk_vld_q   <= 1'b0;
			res_valid_q <= 1'b0;
			status_q    <= tcpa_pkg::ST_CONFIG;
			cpu_q       <= '0;
			util_q      <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			// entry to the scan always sees this low, so no clear on exit is needed
			chk_vld_q <= (state_q == S_SCAN);
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + tcpa_pkg::ADDR_W'(1);
					if (clr_cnt_q == tcpa_pkg::ADDR_W'(tcpa_pkg::DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						// answer now unless the item goes on to the divider
						res_valid_q <= !place_go;
						cpu_q       <= '0;
						util_q      <= '0;
						status_q    <= tcpa_pkg::ST_CONFIG;
						case (action)
							tcpa_pkg::ACT_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= S_CLR;
							end
							tcpa_pkg::ACT_LOAD: begin
								present_q[node_index] <= 1'b1;
							end
							tcpa_pkg::ACT_PLACE: begin
								if (!has_workload) begin
									status_q <= tcpa_pkg::ST_NO_WORKLOAD;
								end else if (!has_target) begin
									status_q <= tcpa_pkg::ST_NO_TARGET;
								end else if (!present_q[node_index]) begin
									status_q <= tcpa_pkg::ST_ABSENT;
								end else if (mask_rd == '0) begin
									status_q <= tcpa_pkg::ST_NO_CPUS;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: begin
								status_q <= tcpa_pkg::ST_CONFIG;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_AFF;
					end
				end
				S_AFF: begin
					state_q <= S_AFFCHK;
				end
				S_AFFCHK: begin
					if (aff_hit) begin
						res_valid_q <= 1'b1;
						status_q    <= tcpa_pkg::ST_PLACED;
						cpu_q       <= aff_cpu_q;
						util_q      <= nu;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						res_valid_q <= 1'b1;
						status_q    <= tcpa_pkg::ST_PLACED;
						cpu_q       <= chk_cpu_q;
						util_q      <= nu;
						state_q     <= S_IDLE;
					end else if (scan_end) begin
						// lowest CPU checked, nothing fits
						res_valid_q <= 1'b1;
						status_q    <= tcpa_pkg::ST_NONE_FITS;
						cpu_q       <= '0;
						util_q      <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign cpu_index = cpu_q;
	assign new_util  = util_q;

endmodule

// File: rtl/tcpa_chk.sv
// Port-level checker for the threshold CPU packing allocator, bound to the top.
// Depends on tcpa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcpa_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [1:0]                     action,
	input logic                           cfg_ready,
	input logic                           res_valid,
	input logic [2:0]                     status,
	input logic [tcpa_pkg::CPU_W-1:0]     cpu_index,
	input logic [tcpa_pkg::UTIL_BITS-1:0] new_util
);

	logic acc_clear;
	logic acc_load;
	logic res_failed;

	assign acc_clear  = start && !busy && action == tcpa_pkg::ACT_CLEAR;
	assign acc_load   = start && !busy && action == tcpa_pkg::ACT_LOAD;
	assign res_failed = res_valid && status != tcpa_pkg::ST_PLACED;

	`CHK_NEXT(a_clear_busy, acc_clear, busy)
	`CHK_NEXT(a_load_answer, acc_load, res_valid && status == tcpa_pkg::ST_CONFIG)
	`CHK_IMPLY(a_fail_zero, res_failed, cpu_index == '0 && new_util == '0)
	`CHK_IMPLY(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind threshold_cpu_packing_allocator_unit tcpa_chk u_tcpa_chk (.*);
